// ===== rtl/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the incremental PID controller
// Field widths, register indexes, the configuration bundle and the
// pipeline load strobes that travel between the controller's modules.
// ----------------------------------------------------------------------------
package pidc_pkg;

	// Field and datapath widths.
	localparam int SAMPLE_W  = 16;  // target and measured samples
	localparam int ERR_W     = 17;  // target - measured
	localparam int DP_W      = 18;  // error - previous error
	localparam int DD_W      = 19;  // error - 2*previous + older
	localparam int GAIN_W    = 16;  // signed Q8.8 gains
	localparam int ILIM_W    = 16;  // integral clamp
	localparam int INC_LIM_W = 39;  // increment clamp, Q.8
	localparam int PROD_W    = 35;  // widest gain product
	localparam int SUM_W     = 37;  // sum of the three products
	localparam int INC_W     = 40;  // sum and limit compared side by side
	localparam int ACC_W     = 48;  // output accumulator, Q.8
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INC_LIM = 3'd4;

	// Accumulator saturation bounds.
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [ILIM_W-1:0]        int_lim;
		logic [INC_LIM_W-1:0]     inc_lim;
	} cfg_t;

	// Load strobes for each pipeline register.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_out;
	} pipe_ctrl_t;

endpackage

// ===== rtl/pidc_err.sv =====
// ----------------------------------------------------------------------------
// pidc_err: error terms and error history
// Forms the error of a sample and its proportional, clamped integral and
// derivative differences, and shifts the two-deep error history.
// ----------------------------------------------------------------------------
module pidc_err (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pidc_pkg::pipe_ctrl_t                  ctrl,
	input  pidc_pkg::cfg_t                        cfg,
	input  logic signed [pidc_pkg::SAMPLE_W-1:0]  target_s1,
	input  logic signed [pidc_pkg::SAMPLE_W-1:0]  measured_s1,
	output logic signed [pidc_pkg::DP_W-1:0]      dp_s2,
	output logic signed [pidc_pkg::ERR_W-1:0]     di_s2,
	output logic signed [pidc_pkg::DD_W-1:0]      dd_s2
);

	logic signed [pidc_pkg::ERR_W-1:0]  prev_err_q;
	logic signed [pidc_pkg::ERR_W-1:0]  older_err_q;
	logic signed [pidc_pkg::ERR_W-1:0]  err;
	logic signed [pidc_pkg::ERR_W:0]    err_x;
	logic signed [pidc_pkg::ERR_W:0]    lim_x;
	logic signed [pidc_pkg::ERR_W-1:0]  di;
	logic signed [pidc_pkg::DP_W-1:0]   dp;
	logic signed [pidc_pkg::DD_W-1:0]   dd;

	// Error and its differences against the history.
	assign err   = pidc_pkg::ERR_W'(target_s1) - pidc_pkg::ERR_W'(measured_s1);
	assign dp    = pidc_pkg::DP_W'(err) - pidc_pkg::DP_W'(prev_err_q);
	assign dd    = pidc_pkg::DD_W'(err) - (pidc_pkg::DD_W'(prev_err_q) <<< 1)
	             + pidc_pkg::DD_W'(older_err_q);

	// Clamp the error to the symmetric integral limit.
	assign err_x = (pidc_pkg::ERR_W+1)'(err);
	assign lim_x = (pidc_pkg::ERR_W+1)'(cfg.int_lim);

	always_comb begin
		if (err_x > lim_x) begin
			di = pidc_pkg::ERR_W'(lim_x);
		end else if (err_x < -lim_x) begin
			di = pidc_pkg::ERR_W'(-lim_x);
		end else begin
			di = err;
		end
	end

	// Error history shifts once per sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			older_err_q <= '0;
		end else if (ctrl.ld_s2) begin
			prev_err_q  <= err;
			older_err_q <= prev_err_q;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			dp_s2 <= dp;
			di_s2 <= di;
			dd_s2 <= dd;
		end
	end

endmodule

// ===== rtl/pidc_mac.sv =====
// ----------------------------------------------------------------------------
// pidc_mac: gain products and clamped increment
// Multiplies each term by its gain in one stage, then sums the products and
// clamps the sum to the symmetric increment limit in the next.
// ----------------------------------------------------------------------------
module pidc_mac (
	input  logic                                clk,
	input  pidc_pkg::pipe_ctrl_t                ctrl,
	input  pidc_pkg::cfg_t                      cfg,
	input  logic signed [pidc_pkg::DP_W-1:0]    dp_s2,
	input  logic signed [pidc_pkg::ERR_W-1:0]   di_s2,
	input  logic signed [pidc_pkg::DD_W-1:0]    dd_s2,
	output logic signed [pidc_pkg::SUM_W-1:0]   inc_s4
);

	logic signed [pidc_pkg::PROD_W-1:0] prod_p;
	logic signed [pidc_pkg::PROD_W-1:0] prod_i;
	logic signed [pidc_pkg::PROD_W-1:0] prod_d;
	logic signed [pidc_pkg::PROD_W-1:0] prod_p_s3;
	logic signed [pidc_pkg::PROD_W-1:0] prod_i_s3;
	logic signed [pidc_pkg::PROD_W-1:0] prod_d_s3;
	logic signed [pidc_pkg::SUM_W-1:0]  sum;
	logic signed [pidc_pkg::INC_W-1:0]  sum_x;
	logic signed [pidc_pkg::INC_W-1:0]  lim_x;
	logic signed [pidc_pkg::SUM_W-1:0]  inc;

	// Three parallel gain multipliers.
	assign prod_p = cfg.gain_p * dp_s2;
	assign prod_i = cfg.gain_i * di_s2;
	assign prod_d = cfg.gain_d * dd_s2;

	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			prod_d_s3 <= prod_d;
		end
	end

	// Exact sum, then clamp to the increment limit. A clamped value is
	// smaller than the sum in magnitude, so it fits the sum width.
	assign sum   = pidc_pkg::SUM_W'(prod_p_s3) + pidc_pkg::SUM_W'(prod_i_s3)
	             + pidc_pkg::SUM_W'(prod_d_s3);
	assign sum_x = pidc_pkg::INC_W'(sum);
	assign lim_x = pidc_pkg::INC_W'(cfg.inc_lim);

	always_comb begin
		if (sum_x > lim_x) begin
			inc = pidc_pkg::SUM_W'(lim_x);
		end else if (sum_x < -lim_x) begin
			inc = pidc_pkg::SUM_W'(-lim_x);
		end else begin
			inc = sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s4) begin
			inc_s4 <= inc;
		end
	end

endmodule

// ===== rtl/pidc_acc.sv =====
// ----------------------------------------------------------------------------
// pidc_acc: saturating output accumulator
// Adds the clamped increment to the accumulator, saturating at its signed
// range. The accumulator is also the output register.
// ----------------------------------------------------------------------------
module pidc_acc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pidc_pkg::pipe_ctrl_t                ctrl,
	input  logic signed [pidc_pkg::SUM_W-1:0]   inc_s4,
	output logic signed [pidc_pkg::ACC_W-1:0]   acc_q
);

	logic signed [pidc_pkg::ACC_W:0]   acc_sum;
	logic signed [pidc_pkg::ACC_W-1:0] acc_nxt;

	// One guard bit shows overflow in either direction.
	assign acc_sum = (pidc_pkg::ACC_W+1)'(acc_q) + (pidc_pkg::ACC_W+1)'(inc_s4);

	always_comb begin
		if (acc_sum[pidc_pkg::ACC_W] == acc_sum[pidc_pkg::ACC_W-1]) begin
			acc_nxt = acc_sum[pidc_pkg::ACC_W-1:0];
		end else if (acc_sum[pidc_pkg::ACC_W]) begin
			acc_nxt = pidc_pkg::ACC_MIN;
		end else begin
			acc_nxt = pidc_pkg::ACC_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.ld_out) begin
			acc_q <= acc_nxt;
		end
	end

endmodule

// ===== rtl/incremental_pid_controller_top.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_controller_top: incremental (velocity-form) PID controller
// Takes target and measured samples, forms a clamped, gain-weighted
// increment and accumulates it into a saturating 48-bit Q.8 output.
//
// Channel  Direction  Handshake                      Payload
// s_axis   in         s_axis_tvalid/s_axis_tready    target, measured
// m_axis   out        m_axis_tvalid/m_axis_tready    control_out
// cfg      in         cfg_valid/cfg_ready            cfg_addr, cfg_data
//
// One sample is accepted per cycle while no stalled output backs up the stages.
// A result passes the input register and then the error terms, gain products,
// sum and clamp, and the accumulator add. The error history and the
// accumulator each close their feedback loop around their own register.
// Reset clears the configuration, valid flags, error history and accumulator, not the data.
// Each stage holds while the next one is full and not moving, so a stalled
// output still lets requests fill the empty stages in front of it.
// ----------------------------------------------------------------------------
module incremental_pid_controller_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,  // target, measured
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [pidc_pkg::ACC_W-1:0]        m_axis_tdata,  // control_out
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [pidc_pkg::INC_LIM_W-1:0]    cfg_data
);

	pidc_pkg::cfg_t       cfg_q;
	pidc_pkg::pipe_ctrl_t ctrl;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic rdy2, rdy3, rdy4, out_free;
	logic accept;

	logic signed [pidc_pkg::SAMPLE_W-1:0] target_s1;
	logic signed [pidc_pkg::SAMPLE_W-1:0] measured_s1;
	logic signed [pidc_pkg::DP_W-1:0]     dp_s2;
	logic signed [pidc_pkg::ERR_W-1:0]    di_s2;
	logic signed [pidc_pkg::DD_W-1:0]     dd_s2;
	logic signed [pidc_pkg::SUM_W-1:0]    inc_s4;
	logic signed [pidc_pkg::ACC_W-1:0]    acc_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_addr)
				pidc_pkg::REG_GAIN_P:  cfg_q.gain_p  <= cfg_data[pidc_pkg::GAIN_W-1:0];
				pidc_pkg::REG_GAIN_I:  cfg_q.gain_i  <= cfg_data[pidc_pkg::GAIN_W-1:0];
				pidc_pkg::REG_GAIN_D:  cfg_q.gain_d  <= cfg_data[pidc_pkg::GAIN_W-1:0];
				pidc_pkg::REG_INT_LIM: cfg_q.int_lim <= cfg_data[pidc_pkg::ILIM_W-1:0];
				pidc_pkg::REG_INC_LIM: cfg_q.inc_lim <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-stage flow control: a stage loads when it is empty or draining.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign rdy4          = !v_s4 || out_free;
	assign rdy3          = !v_s3 || rdy4;
	assign rdy2          = !v_s2 || rdy3;
	assign s_axis_tready = !v_s1 || rdy2;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Load strobes in member order: stage 2, stage 3, stage 4, output.
	assign ctrl = {v_s1 && rdy2, v_s2 && rdy3, v_s3 && rdy4, v_s4 && out_free};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (out_free) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			target_s1   <= s_axis_tdata[15:0];
			measured_s1 <= s_axis_tdata[31:16];
		end
	end

	pidc_err u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cfg         (cfg_q),
		.target_s1   (target_s1),
		.measured_s1 (measured_s1),
		.dp_s2       (dp_s2),
		.di_s2       (di_s2),
		.dd_s2       (dd_s2)
	);

	pidc_mac u_mac (
		.clk    (clk),
		.ctrl   (ctrl),
		.cfg    (cfg_q),
		.dp_s2  (dp_s2),
		.di_s2  (di_s2),
		.dd_s2  (dd_s2),
		.inc_s4 (inc_s4)
	);

	pidc_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.inc_s4 (inc_s4),
		.acc_q  (acc_q)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = acc_q;

endmodule

// ===== test/pidc_result_checker.sv =====
// ----------------------------------------------------------------------------
// pidc_result_checker: result checker for the incremental PID controller
// Watches the configuration, sample and result channels. Every accepted
// sample is run through a cycle-free model of the controller, and each
// accepted result is compared with the oldest predicted control output.
// ----------------------------------------------------------------------------
module pidc_result_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	input  logic                                  s_axis_tready,
	input  logic [2*pidc_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // target, measured
	input  logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic [pidc_pkg::ACC_W-1:0]            m_axis_tdata,   // control_out
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [pidc_pkg::INC_LIM_W-1:0]        cfg_data,
	output int                                    fail_count,
	output int                                    pending,
	output int                                    checked,
	output int                                    saturated
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the configuration registers.
	logic signed [pidc_pkg::GAIN_W-1:0]  kp;
	logic signed [pidc_pkg::GAIN_W-1:0]  ki;
	logic signed [pidc_pkg::GAIN_W-1:0]  kd;
	logic [pidc_pkg::ILIM_W-1:0]         int_clamp;
	logic [pidc_pkg::INC_LIM_W-1:0]      inc_clamp;

	// Shadow copy of the error history and the output accumulator.
	logic signed [pidc_pkg::ERR_W-1:0]   err_z1;
	logic signed [pidc_pkg::ERR_W-1:0]   err_z2;
	logic signed [pidc_pkg::ACC_W-1:0]   acc_now;

	logic signed [pidc_pkg::ACC_W-1:0]   expected_control [$];
	logic signed [pidc_pkg::ACC_W-1:0]   control_want;
	int                                  mismatches;
	int                                  results;
	int                                  sat_hits;

	// Limits v to the range -lim .. +lim.
	function automatic longint bound_magnitude(input longint v, input longint lim);
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	// Runs one sample through the controller and returns the new output.
	// All terms are formed exactly in 64 bits; they stay far below overflow.
	function automatic logic signed [pidc_pkg::ACC_W-1:0] advance_control(
		input logic signed [pidc_pkg::SAMPLE_W-1:0] tgt,
		input logic signed [pidc_pkg::SAMPLE_W-1:0] meas
	);
		longint err;
		longint d_prop;
		longint d_int;
		longint d_der;
		longint step;
		longint sum;
		err    = longint'(tgt) - longint'(meas);
		d_prop = err - longint'(err_z1);
		d_int  = bound_magnitude(err, longint'(int_clamp));
		d_der  = err - 2 * longint'(err_z1) + longint'(err_z2);
		step   = longint'(kp) * d_prop + longint'(ki) * d_int + longint'(kd) * d_der;
		step   = bound_magnitude(step, longint'(inc_clamp));
		sum    = longint'(acc_now) + step;
		if (sum > longint'(pidc_pkg::ACC_MAX)) begin
			sum = longint'(pidc_pkg::ACC_MAX);
		end else if (sum < longint'(pidc_pkg::ACC_MIN)) begin
			sum = longint'(pidc_pkg::ACC_MIN);
		end
		err_z2  = err_z1;
		err_z1  = pidc_pkg::ERR_W'(err);
		acc_now = pidc_pkg::ACC_W'(sum);
		return acc_now;
	endfunction

	// Channel monitor: configuration, predictions and comparisons.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp         = '0;
			ki         = '0;
			kd         = '0;
			int_clamp  = '0;
			inc_clamp  = '0;
			err_z1     = '0;
			err_z2     = '0;
			acc_now    = '0;
			mismatches = 0;
			results    = 0;
			sat_hits   = 0;
			expected_control.delete();
		end else begin
			// Results first: a request accepted now cannot be answered in this cycle.
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_control.size() == 0) begin
					mismatches++;
					$error("control_out: unexpected result, expected none, actual %0d",
						$signed(m_axis_tdata));
				end else begin
					control_want = expected_control.pop_front();
					results++;
					if (m_axis_tdata !== control_want) begin
						mismatches++;
						$error("control_out mismatch: expected %0d, actual %0d",
							control_want, $signed(m_axis_tdata));
					end
				end
			end

			// Register writes; indexes past the register list are ignored.
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					pidc_pkg::REG_GAIN_P:  kp = cfg_data[pidc_pkg::GAIN_W-1:0];
					pidc_pkg::REG_GAIN_I:  ki = cfg_data[pidc_pkg::GAIN_W-1:0];
					pidc_pkg::REG_GAIN_D:  kd = cfg_data[pidc_pkg::GAIN_W-1:0];
					pidc_pkg::REG_INT_LIM: int_clamp = cfg_data[pidc_pkg::ILIM_W-1:0];
					pidc_pkg::REG_INC_LIM: inc_clamp = cfg_data;
					default: ;
				endcase
			end

			// Each accepted request yields exactly one control output.
			if (s_axis_tvalid && s_axis_tready) begin
				control_want = advance_control(s_axis_tdata[pidc_pkg::SAMPLE_W-1:0],
					s_axis_tdata[2*pidc_pkg::SAMPLE_W-1:pidc_pkg::SAMPLE_W]);
				if (control_want == pidc_pkg::ACC_MAX || control_want == pidc_pkg::ACC_MIN)
				begin
					sat_hits++;
				end
				expected_control.push_back(control_want);
			end
		end

		// Published with nonblocking updates so readers see stable values.
		fail_count <= mismatches;
		pending    <= expected_control.size();
		checked    <= results;
		saturated  <= sat_hits;
	end

endmodule

// ===== test/incremental_pid_controller_top_tb.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_controller_top_tb: testbench of the incremental PID top
// Drives corner samples and register settings, then random samples under
// several random settings, then a constant-error run that drives the
// accumulator up and back down. Both stream sides idle at random.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module incremental_pid_controller_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES  = 12;
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 170;
	localparam int SOAK_UP       = 32;
	localparam int SOAK_DOWN     = 32;
	localparam int TAIL_ITEMS    = 40;

	localparam logic signed [pidc_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
		{1'b0, {(pidc_pkg::SAMPLE_W-1){1'b1}}};
	localparam logic signed [pidc_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
		{1'b1, {(pidc_pkg::SAMPLE_W-1){1'b0}}};
	localparam logic signed [pidc_pkg::GAIN_W-1:0]   GAIN_MAX   =
		{1'b0, {(pidc_pkg::GAIN_W-1){1'b1}}};
	localparam logic signed [pidc_pkg::GAIN_W-1:0]   GAIN_MIN   =
		{1'b1, {(pidc_pkg::GAIN_W-1){1'b0}}};
	localparam logic signed [pidc_pkg::GAIN_W-1:0]   GAIN_UNITY = 16'sd256;
	localparam logic [pidc_pkg::INC_LIM_W-1:0]       INC_LIM_MAX = '1;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [2*pidc_pkg::SAMPLE_W-1:0]     s_axis_tdata = '0;     // target, measured
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [pidc_pkg::ACC_W-1:0]          m_axis_tdata;          // control_out
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_addr = '0;
	logic [pidc_pkg::INC_LIM_W-1:0]      cfg_data = '0;

	int                      fail_count;
	int                      pending;
	int                      checked;
	int                      saturated;

	logic                    soak_run = 1'b0;
	logic                    src_calm = 1'b0;
	int                      samples_sent = 0;
	int                      settings_loaded = 0;
	int                      quiet = 0;

	// Corner samples; the repeated swing gives the largest derivative term.
	logic signed [pidc_pkg::SAMPLE_W-1:0] corner_tgt [8] = '{SAMPLE_MAX, SAMPLE_MIN,
		SAMPLE_MAX, 16'sd0, SAMPLE_MIN, SAMPLE_MAX, -16'sd1, 16'sd0};
	logic signed [pidc_pkg::SAMPLE_W-1:0] corner_meas [8] = '{SAMPLE_MIN, SAMPLE_MAX,
		SAMPLE_MIN, 16'sd0, SAMPLE_MIN, SAMPLE_MAX, 16'sd0, -16'sd1};

	incremental_pid_controller_top u_top (.*);

	pidc_result_checker u_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Sends one sample request after a random gap.
	task automatic send_sample(
		input logic signed [pidc_pkg::SAMPLE_W-1:0] tgt,
		input logic signed [pidc_pkg::SAMPLE_W-1:0] meas
	);
		int gap;
		gap = (soak_run || src_calm) ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {meas, tgt};
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
		if ($urandom_range(0, 63) == 0) begin
			src_calm = !src_calm;
		end
	endtask

	// Stops sending and waits until every predicted result has come out.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(
		input logic [pidc_pkg::CFG_IDX_W-1:0] addr,
		input logic [pidc_pkg::INC_LIM_W-1:0] data
	);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all five registers; bits above a register's width carry noise.
	task automatic load_settings(
		input logic signed [pidc_pkg::GAIN_W-1:0] gp,
		input logic signed [pidc_pkg::GAIN_W-1:0] gi,
		input logic signed [pidc_pkg::GAIN_W-1:0] gd,
		input logic [pidc_pkg::ILIM_W-1:0]        il,
		input logic [pidc_pkg::INC_LIM_W-1:0]     incl
	);
		logic [pidc_pkg::INC_LIM_W-1:0] junk;
		junk = pidc_pkg::INC_LIM_W'({$urandom(), $urandom()});
		write_reg(pidc_pkg::REG_GAIN_P,
			{junk[pidc_pkg::INC_LIM_W-1:pidc_pkg::GAIN_W], gp});
		write_reg(pidc_pkg::REG_GAIN_I,
			{junk[pidc_pkg::INC_LIM_W-1:pidc_pkg::GAIN_W], gi});
		write_reg(pidc_pkg::REG_GAIN_D,
			{junk[pidc_pkg::INC_LIM_W-1:pidc_pkg::GAIN_W], gd});
		write_reg(pidc_pkg::REG_INT_LIM,
			{junk[pidc_pkg::INC_LIM_W-1:pidc_pkg::ILIM_W], il});
		write_reg(pidc_pkg::REG_INC_LIM, incl);
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	function automatic logic signed [pidc_pkg::GAIN_W-1:0] draw_gain();
		case ($urandom_range(0, 3))
			0: return pidc_pkg::GAIN_W'($urandom());
			1: return $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
			2: return pidc_pkg::GAIN_W'(int'($urandom_range(0, 1024)) - 512);
			default: return GAIN_UNITY;
		endcase
	endfunction

	task automatic load_random_settings();
		logic signed [pidc_pkg::GAIN_W-1:0] gp;
		logic signed [pidc_pkg::GAIN_W-1:0] gi;
		logic signed [pidc_pkg::GAIN_W-1:0] gd;
		logic [pidc_pkg::ILIM_W-1:0]        il;
		logic [pidc_pkg::INC_LIM_W-1:0]     incl;
		gp = draw_gain();
		gi = draw_gain();
		gd = draw_gain();
		case ($urandom_range(0, 3))
			0: il = '0;
			1: il = '1;
			2: il = pidc_pkg::ILIM_W'($urandom());
			default: il = pidc_pkg::ILIM_W'($urandom_range(0, 2000));
		endcase
		// Small limits make the increment clamp bite; wide ones leave it open.
		case ($urandom_range(0, 4))
			0: incl = '0;
			1: incl = INC_LIM_MAX;
			2: incl = pidc_pkg::INC_LIM_W'({$urandom(), $urandom()});
			3: incl = pidc_pkg::INC_LIM_W'($urandom());
			default: incl = pidc_pkg::INC_LIM_W'($urandom_range(0, 1 << 20));
		endcase
		load_settings(gp, gi, gd, il, incl);
	endtask

	// Full-range, tracking, corner and near-zero samples in equal parts.
	task automatic send_random_sample();
		logic signed [pidc_pkg::SAMPLE_W-1:0] tgt;
		logic signed [pidc_pkg::SAMPLE_W-1:0] meas;
		int base;
		case ($urandom_range(0, 3))
			0: begin
				tgt  = pidc_pkg::SAMPLE_W'($urandom());
				meas = pidc_pkg::SAMPLE_W'($urandom());
			end
			1: begin
				base = int'($urandom_range(0, 60000)) - 30000;
				tgt  = pidc_pkg::SAMPLE_W'(base);
				meas = pidc_pkg::SAMPLE_W'(base + int'($urandom_range(0, 600)) - 300);
			end
			2: begin
				tgt  = corner_tgt[$urandom_range(0, 7)];
				meas = corner_meas[$urandom_range(0, 7)];
			end
			default: begin
				tgt  = pidc_pkg::SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
				meas = pidc_pkg::SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
			end
		endcase
		send_sample(tgt, meas);
	endtask

	task automatic send_corners();
		for (int i = 0; i < 8; i++) begin
			send_sample(corner_tgt[i], corner_meas[i]);
		end
	endtask

	// Result side: random stalls before each result, with calm stretches.
	initial begin
		int  gap;
		logic sink_calm;
		sink_calm = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = (soak_run || sink_calm) ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if ($urandom_range(0, 47) == 0) begin
				sink_calm = !sink_calm;
			end
		end
	end

	// Ends the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Watchdog: no request moved for %0d cycles, %0d results pending",
					QUIET_LIMIT, pending);
				$display("incremental_pid_controller_top_tb failed");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values leave both limits at zero, so the output holds at zero.
		send_sample(SAMPLE_MAX, SAMPLE_MIN);
		send_sample(SAMPLE_MIN, SAMPLE_MAX);
		settle();

		// Zero integral limit with an open increment clamp.
		load_settings(GAIN_UNITY, GAIN_MIN, GAIN_MAX, '0, INC_LIM_MAX);
		send_corners();
		settle();

		// Extreme gains of both signs, widest integral limit.
		load_settings(GAIN_MIN, GAIN_MAX, GAIN_MIN, '1, INC_LIM_MAX);
		send_corners();
		settle();

		// Writes to indexes past the register list must change nothing.
		for (int i = int'(pidc_pkg::REG_INC_LIM) + 1; i < (1 << pidc_pkg::CFG_IDX_W); i++)
		begin
			write_reg(pidc_pkg::CFG_IDX_W'(i),
				pidc_pkg::INC_LIM_W'({$urandom(), $urandom()}));
		end
		// A one-LSB increment limit clamps nearly every step.
		load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, 16'd1000, pidc_pkg::INC_LIM_W'(1));
		send_corners();
		settle();

		// Random samples under a fresh random setting per phase.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_random_settings();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_random_sample();
				// Once, hold the sender back until the pipeline has emptied.
				if (p == 2 && n == PHASE_ITEMS / 2) begin
					settle();
				end
			end
			settle();
		end

		// Constant full-scale error through the integral path only: the
		// accumulator climbs in large equal steps, then falls back again.
		load_settings('0, GAIN_MAX, '0, '1, INC_LIM_MAX);
		soak_run <= 1'b1;
		repeat (SOAK_UP) send_sample(SAMPLE_MAX, SAMPLE_MIN);
		repeat (SOAK_DOWN) send_sample(SAMPLE_MIN, SAMPLE_MAX);
		soak_run <= 1'b0;
		settle();

		// A short random stretch to finish.
		load_random_settings();
		repeat (TAIL_ITEMS) send_random_sample();
		settle();

		$display("Run covered %0d samples under %0d register settings; %0d results checked.",
			samples_sent, settings_loaded, checked);
		$display("Results that sat on a saturation bound: %0d.", saturated);
		if (fail_count == 0) begin
			$display("incremental_pid_controller_top_tb passed");
		end else begin
			$display("incremental_pid_controller_top_tb failed");
		end
		$finish;
	end

endmodule
